[rtl/wrp_pkg.sv]
// Shared types, codes and waveform tables of the waveform record and playback block.
`timescale 1ns / 1ps

package wrp_pkg;

    // Buffer and table geometry
    localparam int SAMPLES  = 20;
    localparam int POS_W    = 5;
    localparam int SAMPLE_W = 10;
    localparam logic [POS_W-1:0] SAMPLES_POS = POS_W'(SAMPLES);

    // Operating modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SINE = 3'd1;
    localparam logic [2:0] MODE_TRI  = 3'd2;
    localparam logic [2:0] MODE_REC  = 3'd3;
    localparam logic [2:0] MODE_PLAY = 3'd4;

    // Input actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_MODE  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_RANGE = 2'd3;

    // Amplitude in half units
    localparam logic [2:0] AMP_RESET = 3'd5;
    localparam logic [2:0] AMP_MAX   = 3'd5;

    // Configuration register map (word index)
    localparam logic ADDR_ADC_TEN_BIT = 1'b0;

    // Item information carried from the state update stage to the scaling stage
    typedef struct packed {
        logic [7:0]       tone_dac;
        logic             tone_wr;
        logic             play;
        logic             entry_valid;
        logic [2:0]       mode;
        logic [POS_W-1:0] pos;
        logic             armed;
        logic [1:0]       range_sel;
        logic [2:0]       amp;
    } stage_t;

    typedef struct packed {
        logic [7:0]       dac_value;
        logic             dac_write;
        logic [2:0]       mode_now;
        logic [POS_W-1:0] buffer_position;
        logic             recording_armed;
        logic [1:0]       range_select;
        logic [2:0]       amplitude_halves;
    } result_t;

    function automatic logic [6:0] sine_value(input logic [POS_W-1:0] idx);
        logic [6:0] v;
        case (idx)
            5'd0:    v = 7'd51;
            5'd1:    v = 7'd67;
            5'd2:    v = 7'd81;
            5'd3:    v = 7'd92;
            5'd4:    v = 7'd100;
            5'd5:    v = 7'd102;
            5'd6:    v = 7'd100;
            5'd7:    v = 7'd92;
            5'd8:    v = 7'd81;
            5'd9:    v = 7'd67;
            5'd10:   v = 7'd51;
            5'd11:   v = 7'd35;
            5'd12:   v = 7'd21;
            5'd13:   v = 7'd10;
            5'd14:   v = 7'd2;
            5'd15:   v = 7'd0;
            5'd16:   v = 7'd2;
            5'd17:   v = 7'd10;
            5'd18:   v = 7'd21;
            5'd19:   v = 7'd35;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] tri_value(input logic [POS_W-1:0] idx);
        logic [6:0] v;
        case (idx)
            5'd0:    v = 7'd51;
            5'd1:    v = 7'd61;
            5'd2:    v = 7'd71;
            5'd3:    v = 7'd82;
            5'd4:    v = 7'd92;
            5'd5:    v = 7'd102;
            5'd6:    v = 7'd92;
            5'd7:    v = 7'd82;
            5'd8:    v = 7'd71;
            5'd9:    v = 7'd61;
            5'd10:   v = 7'd51;
            5'd11:   v = 7'd41;
            5'd12:   v = 7'd31;
            5'd13:   v = 7'd20;
            5'd14:   v = 7'd10;
            5'd15:   v = 7'd0;
            5'd16:   v = 7'd10;
            5'd17:   v = 7'd20;
            5'd18:   v = 7'd31;
            5'd19:   v = 7'd41;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/wrp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module wrp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/wrp_ctrl.sv]
// Mode, position, amplitude and range state, buffer addressing and tone sample generation.
`timescale 1ns / 1ps

module wrp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [1:0]                   action,
    input  logic [wrp_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                         ram_wr_en,
    output logic [wrp_pkg::POS_W-1:0]    ram_wr_addr,
    output logic [wrp_pkg::SAMPLE_W-1:0] ram_wr_data,
    output logic                         ram_rd_en,
    output logic [wrp_pkg::POS_W-1:0]    ram_rd_addr,
    output wrp_pkg::stage_t              info
);

    logic [2:0]                   mode_reg, mode_next;
    logic [wrp_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                         armed_reg, armed_next;
    logic [2:0]                   amp_reg, amp_next;
    logic [1:0]                   range_reg, range_next;
    logic [wrp_pkg::SAMPLES-1:0]  filled_reg, filled_next;
    wrp_pkg::stage_t              info_reg, info_next;

    logic                         tone;
    logic [wrp_pkg::POS_W-1:0]    ridx;
    logic [wrp_pkg::POS_W-1:0]    ridx_inc;
    logic [wrp_pkg::POS_W-1:0]    pos_wrap;
    logic [6:0]                   tab_val;
    logic [9:0]                   tone_prod;
    logic [8:0]                   tone_half;
    logic [3:0]                   amp_sum;
    logic                         rec_write;
    logic                         play_read;

    always_comb
    begin
        tone      = mode_reg inside {wrp_pkg::MODE_SINE, wrp_pkg::MODE_TRI};
        ridx      = (pos_reg < wrp_pkg::SAMPLES_POS) ? pos_reg : '0;
        ridx_inc  = ridx + 5'd1;
        pos_wrap  = (ridx_inc >= wrp_pkg::SAMPLES_POS) ? '0 : ridx_inc;
        tab_val   = (mode_reg == wrp_pkg::MODE_SINE) ? wrp_pkg::sine_value(ridx)
                                                     : wrp_pkg::tri_value(ridx);
        tone_prod = 10'(tab_val) * 10'(amp_reg);
        tone_half = tone_prod[9:1];
        amp_sum   = {1'b0, amp_reg} + 4'd2;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        armed_next  = armed_reg;
        amp_next    = amp_reg;
        range_next  = range_reg;
        filled_next = filled_reg;
        rec_write   = 1'b0;
        play_read   = 1'b0;

        info_next.tone_dac    = 8'd0;
        info_next.tone_wr     = 1'b0;
        info_next.play        = 1'b0;
        info_next.entry_valid = filled_reg[ridx];

        case (action)
            wrp_pkg::ACT_TICK:
            begin
                if (tone)
                begin
                    info_next.tone_dac = (tone_half > 9'd255) ? 8'hFF : tone_half[7:0];
                    info_next.tone_wr  = 1'b1;
                    pos_next           = pos_wrap;
                end
                else if (mode_reg == wrp_pkg::MODE_PLAY)
                begin
                    info_next.play = 1'b1;
                    play_read      = 1'b1;
                    pos_next       = pos_wrap;
                end
                else if (mode_reg == wrp_pkg::MODE_REC)
                begin
                    if (armed_reg && (pos_reg < wrp_pkg::SAMPLES_POS))
                    begin
                        rec_write            = 1'b1;
                        filled_next[pos_reg] = 1'b1;
                        pos_next             = pos_reg + 5'd1;
                    end
                end
            end
            wrp_pkg::ACT_MODE:
            begin
                mode_next  = (mode_reg >= wrp_pkg::MODE_PLAY) ? wrp_pkg::MODE_IDLE
                                                              : mode_reg + 3'd1;
                pos_next   = '0;
                armed_next = 1'b0;
            end
            wrp_pkg::ACT_START:
            begin
                if (mode_reg inside {wrp_pkg::MODE_REC, wrp_pkg::MODE_PLAY})
                begin
                    pos_next   = '0;
                    armed_next = 1'b1;
                end
                else if (tone)
                begin
                    amp_next = (amp_sum > {1'b0, wrp_pkg::AMP_MAX}) ? 3'd0 : amp_sum[2:0];
                end
            end
            wrp_pkg::ACT_RANGE:
            begin
                if (tone)
                begin
                    range_next = (range_reg >= 2'd2) ? 2'd0 : range_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        info_next.mode      = mode_next;
        info_next.pos       = pos_next;
        info_next.armed     = armed_next;
        info_next.range_sel = range_next;
        info_next.amp       = amp_next;
    end

    // Each item touches the buffer at most once, so a write and a read never meet in the same
    // cycle, and a read in the cycle after a write already sees the new entry.
    assign ram_wr_en   = accept && rec_write;
    assign ram_wr_addr = pos_reg;
    assign ram_wr_data = adc_sample;
    assign ram_rd_en   = accept && play_read;
    assign ram_rd_addr = ridx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= wrp_pkg::MODE_REC;
            pos_reg    <= '0;
            armed_reg  <= 1'b0;
            amp_reg    <= wrp_pkg::AMP_RESET;
            range_reg  <= 2'd0;
            filled_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            armed_reg  <= armed_next;
            amp_reg    <= amp_next;
            range_reg  <= range_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

[rtl/wrp_scale.sv]
// Playback scaling, result register and the flow control of both channels.
`timescale 1ns / 1ps

module wrp_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    output logic                         accept,
    input  logic                         out_ready,
    output logic                         out_valid,
    input  wrp_pkg::stage_t              info,
    input  logic [wrp_pkg::SAMPLE_W-1:0] rd_data,
    input  logic                         adc_ten_bit,
    output wrp_pkg::result_t             result
);

    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    wrp_pkg::result_t result_reg, result_next;

    logic             s1_adv;
    logic [9:0]       smp;
    logic [17:0]      prod;
    logic [17:0]      q_sum;
    logic [7:0]       q_est;
    logic [18:0]      rem;
    logic [8:0]       q_fix;
    logic [7:0]       play_val;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // Entries never written since reset read as zero.
        smp   = info.entry_valid ? rd_data : 10'd0;
        prod  = {smp, 8'd0} - 18'(smp);
        // Division by 1023 via 1/1024 + 1/1024^2, then one correction step.
        q_sum = prod + (prod >> 10);
        q_est = q_sum[17:10];
        rem   = 19'(prod) - {1'b0, q_est, 10'd0} + 19'(q_est);
        q_fix = (rem >= 19'd1023) ? {1'b0, q_est} + 9'd1 : {1'b0, q_est};

        if (adc_ten_bit)
        begin
            play_val = q_fix[7:0];
        end
        else
        begin
            play_val = (smp > 10'd255) ? 8'hFF : smp[7:0];
        end

        result_next.dac_value        = info.play ? play_val : info.tone_dac;
        result_next.dac_write        = info.play || info.tone_wr;
        result_next.mode_now         = info.mode;
        result_next.buffer_position  = info.pos;
        result_next.recording_armed  = info.armed;
        result_next.range_select     = info.range_sel;
        result_next.amplitude_halves = info.amp;

        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

[rtl/waveform_record_playback_top.sv]
// Top level of the waveform record and playback generator with its configuration port.
`timescale 1ns / 1ps

// Five-mode DAC sample generator: idle, sine, triangle, record and playback. Each input beat
// is a sample tick or a button event and yields exactly one result beat that reports the state
// after it. One beat is accepted every cycle while the result side keeps up. An accepted beat
// passes two register stages, the registered read of the 20-entry sample buffer and then the
// result register, before its result beat is shown, and waits in the first stage while the
// result side stalls. The buffer starts cleared after reset without a clearing pass: per-entry
// fill flags make unwritten entries read as zero. The register adc_ten_bit (byte address 0)
// selects 10-bit or 8-bit full scale for playback and may only be written while no beat is in
// flight.
module waveform_record_playback_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [9:0]  adc_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  dac_value,
    output logic        dac_write,
    output logic [2:0]  mode_now,
    output logic [4:0]  buffer_position,
    output logic        recording_armed,
    output logic [1:0]  range_select,
    output logic [2:0]  amplitude_halves
);

    logic                         adc_ten_bit_reg, adc_ten_bit_next;
    logic                         cfg_wr;
    logic                         accept;
    logic                         ram_wr_en;
    logic [wrp_pkg::POS_W-1:0]    ram_wr_addr;
    logic [wrp_pkg::SAMPLE_W-1:0] ram_wr_data;
    logic                         ram_rd_en;
    logic [wrp_pkg::POS_W-1:0]    ram_rd_addr;
    logic [wrp_pkg::SAMPLE_W-1:0] ram_rd_data;
    wrp_pkg::stage_t              info;
    wrp_pkg::result_t             result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        adc_ten_bit_next = adc_ten_bit_reg;
        if (cfg_wr && (paddr[2] == wrp_pkg::ADDR_ADC_TEN_BIT))
        begin
            adc_ten_bit_next = pwdata[0];
        end
        prdata = (paddr[2] == wrp_pkg::ADDR_ADC_TEN_BIT) ? {31'd0, adc_ten_bit_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_ten_bit_reg <= 1'b1;
        end
        else
        begin
            adc_ten_bit_reg <= adc_ten_bit_next;
        end
    end

    wrp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .adc_sample  (adc_sample),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .info        (info)
    );

    wrp_ram #(
        .WIDTH (wrp_pkg::SAMPLE_W),
        .DEPTH (wrp_pkg::SAMPLES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    wrp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .accept      (accept),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .info        (info),
        .rd_data     (ram_rd_data),
        .adc_ten_bit (adc_ten_bit_reg),
        .result      (result)
    );

    assign dac_value        = result.dac_value;
    assign dac_write        = result.dac_write;
    assign mode_now         = result.mode_now;
    assign buffer_position  = result.buffer_position;
    assign recording_armed  = result.recording_armed;
    assign range_select     = result.range_select;
    assign amplitude_halves = result.amplitude_halves;

endmodule

[rtl/wrp_checker.sv]
// Port-level assertions for the waveform record and playback block, bound to its top level.
`timescale 1ns / 1ps

module wrp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] dac_value,
    input logic       dac_write,
    input logic [2:0] mode_now,
    input logic       recording_armed
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dac_value))
    else $error("result beat changed while stalled");

    // The input side only stalls while a result waits to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

    // Only tone and playback ticks drive the DAC.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dac_write |-> (mode_now == wrp_pkg::MODE_SINE) ||
                                   (mode_now == wrp_pkg::MODE_TRI) ||
                                   (mode_now == wrp_pkg::MODE_PLAY))
    else $error("DAC written outside a generating mode");

    // Start is only armed in record or playback.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((mode_now == wrp_pkg::MODE_IDLE) || (mode_now == wrp_pkg::MODE_SINE) ||
                      (mode_now == wrp_pkg::MODE_TRI)) |-> !recording_armed)
    else $error("armed outside record or playback");

endmodule

bind waveform_record_playback_top wrp_checker u_wrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dac_value       (dac_value),
    .dac_write       (dac_write),
    .mode_now        (mode_now),
    .recording_armed (recording_armed)
);
